// ===== rtl/dle_voice_stream_deframer_assert.svh =====
// assertion macros for the checker file
`ifndef DLE_VOICE_STREAM_DEFRAMER_ASSERT_SVH
`define DLE_VOICE_STREAM_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define DVSD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// next-cycle implication, sampled on clock, off during reset
`define DVSD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

// ===== rtl/dvsd_pkg.sv =====
package dvsd_pkg;

   typedef enum logic [2:0] {
      KIND_ABSORBED = 3'd0,
      KIND_DATA     = 3'd1,
      KIND_EVENT    = 3'd2,
      KIND_END      = 3'd3,
      KIND_UNKNOWN  = 3'd4,
      KIND_TRAILING = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      EV_DTMF      = 4'd0,
      EV_DATA_FAX  = 4'd1,
      EV_BUSY      = 4'd2,
      EV_FAX_CALL  = 4'd3,
      EV_DIAL      = 4'd4,
      EV_DATA_CALL = 4'd5,
      EV_ONHOOK    = 4'd6,
      EV_OFFHOOK   = 4'd7,
      EV_SILENCE   = 4'd8,
      EV_NO_ENERGY = 4'd9,
      EV_OVERRUN   = 4'd10,
      EV_UNDERRUN  = 4'd11
   } ev_code_type;

   localparam logic [7:0] CODE_DLE = 8'h10;
   localparam logic [7:0] CODE_ETX = 8'h03;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_D  = 8'h44;
   localparam logic [7:0] CHAR_UP_T  = 8'h54;
   localparam logic [7:0] CHAR_STAR  = 8'h2a;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_B     = 8'h62;
   localparam logic [7:0] CHAR_C     = 8'h63;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_F     = 8'h66;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_Q     = 8'h71;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;

   localparam logic [3:0] DIGIT_STAR = 4'd10;
   localparam logic [3:0] DIGIT_HASH = 4'd11;
   // low nibble of 'A' is 1, digit for 'A' is 12
   localparam logic [3:0] DIGIT_LETTER_OFFSET = 4'd11;

endpackage

// ===== rtl/dle_voice_stream_deframer.sv =====
// DLE voice stream deframer: takes the modem receive byte stream one byte per
// transfer and gives exactly one result per byte, in order. A DLE byte opens an
// escape and is reported as absorbed; the escaped byte becomes a data byte 0x10
// (DLE DLE), the end of the recording (DLE ETX), an event (with its DTMF digit
// for a DTMF tone), an absorbed 'T' or an unknown code. After the end every
// byte is passed on as a trailing byte until reset. A byte can be taken in
// every cycle unless the result stalls, and passes through the input register
// and then the result register; the escape and end flags are updated as it
// moves between them. Reset clears both flags and empties both stages.
module dle_voice_stream_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_out,
   output logic [3:0] rsp_event_code,
   output logic [3:0] rsp_dtmf_digit
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       escape_ff, escape_in;
   logic       ended_ff, ended_in;
   logic       out_valid_ff;
   dvsd_pkg::kind_type kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [3:0] event_ff, event_in;
   logic [3:0] digit_ff, digit_in;
   logic       out_free;
   logic       advance;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      escape_in = escape_ff;
      ended_in  = ended_ff;
      kind_in   = dvsd_pkg::KIND_ABSORBED;
      data_in   = 8'h00;
      event_in  = 4'h0;
      digit_in  = 4'h0;
      if (ended_ff) begin
         kind_in = dvsd_pkg::KIND_TRAILING;
         data_in = in_byte_ff;
      end else if (escape_ff) begin
         escape_in = 1'b0;
         kind_in   = dvsd_pkg::KIND_EVENT;
         case (in_byte_ff) inside
            dvsd_pkg::CODE_DLE: begin
               kind_in = dvsd_pkg::KIND_DATA;
               data_in = dvsd_pkg::CODE_DLE;
            end
            dvsd_pkg::CODE_ETX: begin
               kind_in  = dvsd_pkg::KIND_END;
               ended_in = 1'b1;
            end
            dvsd_pkg::CHAR_UP_T: kind_in = dvsd_pkg::KIND_ABSORBED;
            // ascii digits carry their value in the low nibble
            [dvsd_pkg::CHAR_0:dvsd_pkg::CHAR_9]: digit_in = in_byte_ff[3:0];
            [dvsd_pkg::CHAR_UP_A:dvsd_pkg::CHAR_UP_D]:
               digit_in = in_byte_ff[3:0] + dvsd_pkg::DIGIT_LETTER_OFFSET;
            dvsd_pkg::CHAR_STAR: digit_in = dvsd_pkg::DIGIT_STAR;
            dvsd_pkg::CHAR_HASH: digit_in = dvsd_pkg::DIGIT_HASH;
            dvsd_pkg::CHAR_A, dvsd_pkg::CHAR_F: event_in = dvsd_pkg::EV_DATA_FAX;
            dvsd_pkg::CHAR_B: event_in = dvsd_pkg::EV_BUSY;
            dvsd_pkg::CHAR_C: event_in = dvsd_pkg::EV_FAX_CALL;
            dvsd_pkg::CHAR_D: event_in = dvsd_pkg::EV_DIAL;
            dvsd_pkg::CHAR_E: event_in = dvsd_pkg::EV_DATA_CALL;
            dvsd_pkg::CHAR_H: event_in = dvsd_pkg::EV_ONHOOK;
            dvsd_pkg::CHAR_T: event_in = dvsd_pkg::EV_OFFHOOK;
            dvsd_pkg::CHAR_Q: event_in = dvsd_pkg::EV_SILENCE;
            dvsd_pkg::CHAR_S: event_in = dvsd_pkg::EV_NO_ENERGY;
            dvsd_pkg::CHAR_O: event_in = dvsd_pkg::EV_OVERRUN;
            dvsd_pkg::CHAR_U: event_in = dvsd_pkg::EV_UNDERRUN;
            default: begin
               kind_in = dvsd_pkg::KIND_UNKNOWN;
               data_in = in_byte_ff;
            end
         endcase
      end else if (in_byte_ff == dvsd_pkg::CODE_DLE) begin
         escape_in = 1'b1;
      end else begin
         kind_in = dvsd_pkg::KIND_DATA;
         data_in = in_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         escape_ff    <= 1'b0;
         ended_ff     <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            escape_ff <= escape_in;
            ended_ff  <= ended_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         kind_ff  <= kind_in;
         data_ff  <= data_in;
         event_ff <= event_in;
         digit_ff <= digit_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_data_out   = data_ff;
   assign rsp_event_code = event_ff;
   assign rsp_dtmf_digit = digit_ff;

endmodule

// ===== rtl/dvsd_checker.sv =====
`include "dle_voice_stream_deframer_assert.svh"

module dvsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data_out,
   input logic [3:0] rsp_event_code,
   input logic [3:0] rsp_dtmf_digit
);

   logic is_event;
   logic no_data;

   assign is_event = rsp_kind == dvsd_pkg::KIND_EVENT;
   assign no_data  = rsp_kind == dvsd_pkg::KIND_ABSORBED || is_event
                     || rsp_kind == dvsd_pkg::KIND_END;

   // a stalled result stays offered
   `DVSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   `DVSD_ASSERT_NOW(a_kind_range, rsp_valid,
      rsp_kind <= dvsd_pkg::KIND_TRAILING && rsp_event_code <= dvsd_pkg::EV_UNDERRUN)

   `DVSD_ASSERT_NOW(a_data_zero, rsp_valid && no_data, rsp_data_out == 8'h00)

   // event fields only ride with events, and only dtmf carries a digit
   `DVSD_ASSERT_NOW(a_event_zero, rsp_valid && (!is_event || rsp_event_code != dvsd_pkg::EV_DTMF),
      rsp_dtmf_digit == 4'h0 && (is_event || rsp_event_code == dvsd_pkg::EV_DTMF))

endmodule

bind dle_voice_stream_deframer dvsd_checker u_dvsd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_data_out   (rsp_data_out),
   .rsp_event_code (rsp_event_code),
   .rsp_dtmf_digit (rsp_dtmf_digit)
);
